[rtl/hssd_pkg.sv]
// Shared types and constants for the header-sync sample deframer.
// Holds register indexes, sample format codes and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hssd_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int SPF_W    = 11;
  localparam int FMT_W    = 3;
  localparam int SAMPLE_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [SPF_W-1:0]      spf_t;
  typedef logic [FMT_W-1:0]      fmt_t;
  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_HEADER_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_HEADER_SECOND = 2'd1;
  localparam cfg_idx_t CFG_SAMPLES       = 2'd2;
  localparam cfg_idx_t CFG_FORMAT        = 2'd3;

  // Sample format codes
  localparam fmt_t FMT_NONE   = 3'd0;
  localparam fmt_t FMT_BYTE   = 3'd1;
  localparam fmt_t FMT_INT16  = 3'd2;
  localparam fmt_t FMT_UINT16 = 3'd3;
  localparam fmt_t FMT_FLOAT  = 3'd4;

endpackage

`default_nettype wire

[rtl/header_sync_sample_deframer.sv]
// Header-sync sample deframer: hunts a two-byte start marker in a byte
// stream and assembles the frame payload into little-endian samples.
// Depends on hssd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte
//   per word. Output channel (out_valid / out_stall / sample_bits /
//   frame_last) gives one assembled sample per word; frame_last marks the
//   last sample of a frame. Bytes of the header and bytes that do not
//   complete a sample give no output word.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   header_first, header_second, samples_per_frame and sample_format;
//   cfg_ready is always high. Write only while no byte is in flight.
//   A byte that completes a sample passes the input register, then the result
//   register, before its word shows on the output. Throughput: one byte per
//   cycle while the output does not stall, set by the single update of the
//   frame state between the input register and the result register.
//   A stall on the output holds the result register; while the input
//   register also holds a word, in_stall is high in that same cycle.
//   Reset (rst, synchronous) empties both registers, restores the register
//   defaults and returns the block to header hunting with an empty window.
`timescale 1ns / 1ps
`default_nettype none

module header_sync_sample_deframer #(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire                   clk,
  input  wire                   rst,
  // byte input
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire hssd_pkg::byte_t  rx_byte,
  // sample output
  output logic                  out_valid,
  input  wire                   out_stall,
  output hssd_pkg::sample_t     sample_bits,
  output logic                  frame_last,
  // configuration writes
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire hssd_pkg::cfg_idx_t  cfg_index,
  input  wire hssd_pkg::cfg_data_t cfg_data
);
  import hssd_pkg::*;

  // Sample counter width and width used for the frame length compare
  localparam int CNT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (LEN_W > SPF_W) ? LEN_W : SPF_W;

  // Configuration registers
  byte_t header_first;
  byte_t header_second;
  spf_t  samples_per_frame;
  fmt_t  sample_format;

  // Input register
  logic  s1_valid;
  byte_t s1_byte;

  // Frame state
  logic             in_frame;
  logic             window_seen;   // at least one byte in the window
  byte_t            window_prev;
  sample_t          assembly;
  logic [1:0]       byte_index;
  logic [CNT_W-1:0] sample_count;

  // Update logic
  logic             out_free;
  logic             proc;
  logic             header_hit;
  sample_t          assembly_next;
  logic [2:0]       byte_count;
  logic [2:0]       sample_bytes;
  logic             sample_done;
  logic [CMP_W-1:0] count_inc;
  logic [CMP_W-1:0] frame_len;
  logic             res_last;
  logic             emit;
  sample_t          res_bits;

  assign cfg_ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first      <= '0;
      header_second     <= '0;
      samples_per_frame <= spf_t'(1);
      sample_format     <= FMT_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  header_first      <= cfg_data[BYTE_W-1:0];
        CFG_HEADER_SECOND: header_second     <= cfg_data[BYTE_W-1:0];
        CFG_SAMPLES:       samples_per_frame <= cfg_data[SPF_W-1:0];
        CFG_FORMAT:        sample_format     <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register advances when the result register frees
  assign out_free = !out_valid || !out_stall;
  assign proc     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  // Header match on the sliding window
  assign header_hit = window_seen && (window_prev == header_first) &&
                      (s1_byte == header_second);

  // Drop the byte into its lane of the assembly word
  always_comb begin
    assembly_next = assembly;
    unique case (byte_index)
      2'd0: assembly_next[7:0]   = assembly[7:0]   | s1_byte;
      2'd1: assembly_next[15:8]  = assembly[15:8]  | s1_byte;
      2'd2: assembly_next[23:16] = assembly[23:16] | s1_byte;
      2'd3: assembly_next[31:24] = assembly[31:24] | s1_byte;
      default: ;
    endcase
  end

  // Bytes per sample for the current format
  always_comb begin
    priority if (sample_format == FMT_INT16 || sample_format == FMT_UINT16) begin
      sample_bytes = 3'd2;
    end else if (sample_format == FMT_FLOAT) begin
      sample_bytes = 3'd4;
    end else begin
      sample_bytes = 3'd1;
    end
  end

  assign byte_count  = {1'b0, byte_index} + 3'd1;
  assign sample_done = byte_count >= sample_bytes;

  // Frame length: zero counts as one, clipped to MAX_SAMPLES
  always_comb begin
    priority if (samples_per_frame == '0) begin
      frame_len = CMP_W'(1);
    end else if (CMP_W'(samples_per_frame) > CMP_W'(MAX_SAMPLES)) begin
      frame_len = CMP_W'(MAX_SAMPLES);
    end else begin
      frame_len = CMP_W'(samples_per_frame);
    end
  end

  assign count_inc = CMP_W'(sample_count) + CMP_W'(1);
  assign res_last  = count_inc >= frame_len;

  // Sample value as the format reads it
  always_comb begin
    emit     = 1'b1;
    res_bits = '0;
    unique case (sample_format)
      FMT_BYTE:   res_bits = {24'd0, assembly_next[7:0]};
      FMT_INT16:  res_bits = {{16{assembly_next[15]}}, assembly_next[15:0]};
      FMT_UINT16: res_bits = {16'd0, assembly_next[15:0]};
      FMT_FLOAT:  res_bits = assembly_next;
      default:    emit     = 1'b0;
    endcase
  end

  // Frame state update, one byte per cycle while the result register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      window_seen  <= 1'b0;
      window_prev  <= '0;
      assembly     <= '0;
      byte_index   <= '0;
      sample_count <= '0;
    end else if (proc) begin
      if (!in_frame) begin
        in_frame    <= header_hit;
        window_seen <= 1'b1;
        window_prev <= s1_byte;
      end else if (!sample_done) begin
        assembly   <= assembly_next;
        byte_index <= byte_count[1:0];
      end else begin
        assembly   <= '0;
        byte_index <= '0;
        if (res_last) begin
          in_frame     <= 1'b0;
          sample_count <= '0;
        end else begin
          sample_count <= count_inc[CNT_W-1:0];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc && in_frame && sample_done && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_frame && sample_done && emit) begin
      sample_bits <= res_bits;
      frame_last  <= res_last;
    end
  end

  // Checks
  a_reset_hunt: assert property (@(posedge clk)
    rst |=> (!in_frame && !out_valid && !s1_valid))
    else $error("block not hunting and empty after reset");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (proc && in_frame && sample_done && res_last) |=> !in_frame)
    else $error("frame still open after its last sample");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (proc && in_frame && sample_done && emit) |=> out_valid)
    else $error("finished sample did not reach the result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with no held result");

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for header_sync_sample_deframer: byte stream in, assembled samples out.
// Predicts every sample word from its own model of header hunting and sample
// assembly, and checks each output word in order. Depends on hssd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import hssd_pkg::*;

  localparam int MAX_SAMPLES    = 1024;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BYTES   = 340;
  localparam int PHASE_BYTES    = 45;
  localparam int PAYLOAD_CAP    = 24;
  localparam int CLOSE_GUARD    = 64;
  localparam int LONG_BYTES     = 150;

  // Format codes 5..7 have no name in the package; they behave like none
  localparam fmt_t FMT_RESERVED = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    sample_t  word_bits;
    logic     last;
  } sample_word_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  byte_t     rx_byte = '0;
  logic      out_stall = 1'b0;
  logic      cfg_valid = 1'b0;
  cfg_idx_t  cfg_index = CFG_HEADER_FIRST;
  cfg_data_t cfg_data = '0;
  logic      in_stall;
  logic      out_valid;
  sample_t   sample_bits;
  logic      frame_last;
  logic      cfg_ready;

  // Register copies and deframer state kept by the predictor
  byte_t   hdr_first = '0;
  byte_t   hdr_second = '0;
  spf_t    spf = 11'd1;
  fmt_t    fmt = FMT_NONE;
  logic    in_frame = 1'b0;
  byte_t   win_prev = '0;
  int      win_fill = 0;
  sample_t asm_word = '0;
  int      asm_idx = 0;
  int      smp_count = 0;

  sample_word_t pending_samples[$];
  sample_word_t want;
  int mismatches = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  header_sync_sample_deframer #(.MAX_SAMPLES(MAX_SAMPLES)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_bits(sample_bits), .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int bytes_per(fmt_t f);
    case (f)
      FMT_INT16, FMT_UINT16: return 2;
      FMT_FLOAT:             return 4;
      default:               return 1;
    endcase
  endfunction

  // Zero counts as one, anything above the maximum saturates
  function automatic int frame_len();
    if (spf == 0) return 1;
    if (spf > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(spf);
  endfunction

  // Advance the predicted deframer by one byte, queue a sample word if one results
  function automatic void deframe_byte(byte_t b);
    sample_word_t w;
    if (!in_frame) begin
      if (win_fill >= 1 && win_prev == hdr_first && b == hdr_second) in_frame = 1'b1;
      if (win_fill < 2) win_fill++;
      win_prev = b;
      return;
    end
    asm_word |= sample_t'(b) << (8 * (asm_idx % 4));
    asm_idx++;
    if (asm_idx < bytes_per(fmt)) return;
    smp_count++;
    w.last = (smp_count >= frame_len());
    case (fmt)
      FMT_BYTE:   w.word_bits = {24'b0, asm_word[7:0]};
      FMT_INT16:  w.word_bits = {{16{asm_word[15]}}, asm_word[15:0]};
      FMT_UINT16: w.word_bits = {16'b0, asm_word[15:0]};
      FMT_FLOAT:  w.word_bits = asm_word;
      default:    w.word_bits = '0;
    endcase
    asm_word = '0;
    asm_idx = 0;
    if (w.last) begin
      in_frame = 1'b0;
      smp_count = 0;
    end
    if (fmt >= FMT_BYTE && fmt <= FMT_FLOAT) begin
      pending_samples.insert(pending_samples.size(), w);
    end
  endfunction

  // Random byte with the extremes weighted up
  function automatic byte_t rand_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return byte_t'($urandom);
  endfunction

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 82; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 82; end
      IDLE_BOTH:     begin send_idle_pct = 17; stall_pct = 17; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Offer one byte, hold it until accepted, then update the prediction
  task automatic send_byte(byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and let every predicted word drain, plus the pipeline depth
  task automatic wait_idle;
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Feed payload until an open frame closes, bounded for very long frames
  task automatic close_frame;
    int guard;
    guard = 0;
    while (in_frame && guard < CLOSE_GUARD) begin
      send_byte(rand_byte());
      guard++;
    end
  endtask

  // Write all four registers back to back; upper data bits may carry junk
  task automatic apply_config(cfg_data_t hf_w, cfg_data_t hs_w, cfg_data_t spf_w,
                              cfg_data_t fmt_w);
    cfg_data_t vals[4];
    vals[CFG_HEADER_FIRST]  = hf_w;
    vals[CFG_HEADER_SECOND] = hs_w;
    vals[CFG_SAMPLES]       = spf_w;
    vals[CFG_FORMAT]        = fmt_w;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    hdr_first  = hf_w[7:0];
    hdr_second = hs_w[7:0];
    spf        = spf_t'(spf_w);
    fmt        = fmt_w[2:0];
  endtask

  // A match needs two bytes seen: the reset window holds zero but must not match
  task automatic test_header_window;
    set_idling(IDLE_NONE);
    apply_config(11'h000, 11'h000, 11'd1, cfg_data_t'(FMT_BYTE));
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  // int16 sign extension at both extremes, several samples per frame
  task automatic test_int16;
    byte_t seq[8] = '{8'hA5, 8'h5A, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF};
    set_idling(IDLE_RECEIVER);
    close_frame();
    wait_idle();
    apply_config(11'h0A5, 11'h05A, 11'd3, cfg_data_t'(FMT_INT16));
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // uint16 zero extension, then float with a frame length of zero
  task automatic test_uint16_float;
    byte_t seq_u[4] = '{8'hA5, 8'h5A, 8'h00, 8'h80};
    byte_t seq_f[6] = '{8'hA5, 8'h5A, 8'h78, 8'h56, 8'h34, 8'hF2};
    set_idling(IDLE_SENDER);
    close_frame();
    wait_idle();
    apply_config(11'h0A5, 11'h05A, 11'd1, cfg_data_t'(FMT_UINT16));
    foreach (seq_u[i]) send_byte(seq_u[i]);
    wait_idle();
    apply_config(11'h0A5, 11'h05A, 11'd0, cfg_data_t'(FMT_FLOAT));
    foreach (seq_f[i]) send_byte(seq_f[i]);
  endtask

  // Format none and a reserved code: bytes counted, frames close, no words
  task automatic test_silent_formats;
    byte_t seq[4] = '{8'hC3, 8'h3C, 8'h11, 8'h22};
    set_idling(IDLE_BOTH);
    close_frame();
    wait_idle();
    apply_config(11'h0C3, 11'h03C, 11'd2, cfg_data_t'(FMT_NONE));
    foreach (seq[i]) send_byte(seq[i]);
    wait_idle();
    apply_config(11'h0C3, 11'h03C, 11'd1, cfg_data_t'(FMT_RESERVED));
    send_byte(8'hC3);
    send_byte(8'h3C);
    send_byte(8'h44);
  endtask

  // Oversized frame length saturates instead of wrapping to its low bits:
  // a long run of byte samples, none flagged last; the frame stays open
  task automatic test_long_frame;
    set_idling(IDLE_NONE);
    close_frame();
    wait_idle();
    apply_config(11'h0FF, 11'h000, 11'h401, cfg_data_t'(FMT_BYTE));
    send_byte(8'hFF);
    send_byte(8'h00);
    repeat (LONG_BYTES) send_byte(rand_byte());
  endtask

  // Phases of random settings; mostly well-formed frames, some noise and
  // broken headers; some phases change settings while a frame is open
  task automatic test_random_traffic;
    int goal;
    int phase;
    int start;
    int r;
    int n;
    byte_t hf;
    byte_t hs;
    fmt_t f;
    cfg_data_t spf_w;
    goal = bytes_sent + RANDOM_BYTES;
    phase = 0;
    while (bytes_sent < goal) begin
      set_idling(idle_mode_t'(phase % 4));
      if ($urandom_range(9) < 7) close_frame();
      wait_idle();
      hf = rand_byte();
      hs = rand_byte();
      case ($urandom_range(9))
        0:       spf_w = 11'd0;
        1:       spf_w = 11'($urandom_range(2047, 1025));
        2:       spf_w = 11'd1024;
        default: spf_w = 11'($urandom_range(6, 1));
      endcase
      case ($urandom_range(9))
        0:       f = fmt_t'($urandom_range(7, 5));
        1:       f = FMT_NONE;
        default: f = fmt_t'($urandom_range(FMT_FLOAT, FMT_BYTE));
      endcase
      apply_config({3'($urandom_range(7)), hf}, {3'($urandom_range(7)), hs}, spf_w,
                   {8'($urandom), f});
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 10) begin
          repeat ($urandom_range(4, 1)) send_byte(byte_t'($urandom));
        end else if (r < 20) begin
          send_byte(hdr_first);
          send_byte(r < 15 ? rand_byte() : hdr_first);
        end else begin
          repeat ($urandom_range(2)) send_byte(byte_t'($urandom));
          send_byte(hdr_first);
          send_byte(hdr_second);
          n = frame_len() * bytes_per(fmt);
          if (n > PAYLOAD_CAP) n = PAYLOAD_CAP;
          repeat (n) send_byte(rand_byte());
        end
      end
      phase++;
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected word: sample_bits=%08h frame_last=%b", sample_bits, frame_last);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (sample_bits !== want.word_bits) begin
          $error("sample_bits: expected %08h, got %08h", want.word_bits, sample_bits);
          mismatches++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last: expected %b, got %b", want.last, frame_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("header_sync_sample_deframer test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_header_window();
    test_int16();
    test_uint16_float();
    test_silent_formats();
    test_long_frame();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("header_sync_sample_deframer test passed");
    end else begin
      $display("header_sync_sample_deframer test failed");
    end
    $finish;
  end

endmodule
